### design/segment_pair_detector_defines.svh
// Assertion macros for the segment pair detector checker.
// Depends on the asserting module having ports named aclk and aresetn.
`ifndef SEGMENT_PAIR_DETECTOR_DEFINES_SVH
`define SEGMENT_PAIR_DETECTOR_DEFINES_SVH

// Next-cycle implication, masked while reset is applied
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset
`define SPD_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/spd_pkg.sv
// Shared types, widths, register indexes and reset values of the segment pair detector.
// No dependencies.
package spd_pkg;

    // field widths
    localparam int COORD_BITS    = 16;
    localparam int OUT_BITS      = 16;
    localparam int RADIUS_BITS   = 16;
    localparam int LEN_BITS      = 14;

    // derived arithmetic widths
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int SUM_SQ_BITS   = SQ_BITS + 1;
    localparam int BOUND_BITS    = LEN_BITS + 1;
    localparam int BOUND_SQ_BITS = 2 * BOUND_BITS;
    localparam int CMP_BITS      = (SUM_SQ_BITS > BOUND_SQ_BITS) ? SUM_SQ_BITS : BOUND_SQ_BITS;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_LOW     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_HIGH    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIDE_LENGTH    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIDE_TOLERANCE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_LENGTH     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_TOLERANCE  = 3'd5;

    localparam logic [RADIUS_BITS-1:0] RADIUS_LOW_RST     = 16'd1000;
    localparam logic [RADIUS_BITS-1:0] RADIUS_HIGH_RST    = 16'd3000;
    localparam logic [LEN_BITS-1:0]    SIDE_LENGTH_RST    = 14'd130;
    localparam logic [LEN_BITS-1:0]    SIDE_TOLERANCE_RST = 14'd30;
    localparam logic [LEN_BITS-1:0]    GAP_LENGTH_RST     = 14'd700;
    localparam logic [LEN_BITS-1:0]    GAP_TOLERANCE_RST  = 14'd500;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic        [RADIUS_BITS-1:0] radius;
        logic                          last_in_scan;
    } spd_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] first_mid_x;
        logic signed [OUT_BITS-1:0] first_mid_y;
        logic signed [OUT_BITS-1:0] second_mid_x;
        logic signed [OUT_BITS-1:0] second_mid_y;
    } spd_out_t;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius_low;
        logic [RADIUS_BITS-1:0] radius_high;
        logic [LEN_BITS-1:0]    side_length;
        logic [LEN_BITS-1:0]    side_tolerance;
        logic [LEN_BITS-1:0]    gap_length;
        logic [LEN_BITS-1:0]    gap_tolerance;
    } spd_cfg_t;

    // one kept segment, already paired with the previous midpoint
    typedef struct packed {
        logic                         has_prev;
        logic signed [COORD_BITS-1:0] prev_mid_x;
        logic signed [COORD_BITS-1:0] prev_mid_y;
        logic signed [COORD_BITS-1:0] mid_x;
        logic signed [COORD_BITS-1:0] mid_y;
        logic signed [DIFF_BITS-1:0]  seg_dx;
        logic signed [DIFF_BITS-1:0]  seg_dy;
        logic signed [DIFF_BITS-1:0]  gap_dx;
        logic signed [DIFF_BITS-1:0]  gap_dy;
    } spd_entry_t;

endpackage

### design/spd_queue.sv
// Small synchronous FIFO between the front and back parts of the detector.
// No package dependency; width and depth come from parameters.
module spd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/spd_front.sv
// Front part: accepts segments, applies the radius window, forms midpoints and
// pairs each kept segment with the previous one. Depends on spd_pkg.
module spd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spd_pkg::spd_in_t    s_data,
    input  spd_pkg::spd_cfg_t   cfg,
    input  logic                q_full,
    output logic                q_push,
    output spd_pkg::spd_entry_t q_data
);
    import spd_pkg::*;

    logic                         accept;
    logic                         kept;
    logic signed [DIFF_BITS-1:0]  sum_x, sum_y;
    logic signed [COORD_BITS-1:0] mid_x, mid_y;

    logic                         have_prev_reg, have_prev_next;
    logic signed [COORD_BITS-1:0] prev_mid_x_reg, prev_mid_x_next;
    logic signed [COORD_BITS-1:0] prev_mid_y_reg, prev_mid_y_next;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    // radius window, both bounds exclusive
    assign kept = (s_data.radius > cfg.radius_low) && (s_data.radius < cfg.radius_high);

    // midpoint = floor of half the sum
    assign sum_x = DIFF_BITS'(s_data.start_x) + DIFF_BITS'(s_data.end_x);
    assign sum_y = DIFF_BITS'(s_data.start_y) + DIFF_BITS'(s_data.end_y);
    assign mid_x = sum_x[DIFF_BITS-1:1];
    assign mid_y = sum_y[DIFF_BITS-1:1];

    // queue entry
    always_comb begin
        q_data.has_prev   = have_prev_reg;
        q_data.prev_mid_x = prev_mid_x_reg;
        q_data.prev_mid_y = prev_mid_y_reg;
        q_data.mid_x      = mid_x;
        q_data.mid_y      = mid_y;
        q_data.seg_dx     = DIFF_BITS'(s_data.end_x) - DIFF_BITS'(s_data.start_x);
        q_data.seg_dy     = DIFF_BITS'(s_data.end_y) - DIFF_BITS'(s_data.start_y);
        q_data.gap_dx     = DIFF_BITS'(mid_x) - DIFF_BITS'(prev_mid_x_reg);
        q_data.gap_dy     = DIFF_BITS'(mid_y) - DIFF_BITS'(prev_mid_y_reg);
    end

    assign q_push = accept && kept;

    // pairing state: last kept midpoint of this scan, cleared at end of scan
    always_comb begin
        have_prev_next  = have_prev_reg;
        prev_mid_x_next = prev_mid_x_reg;
        prev_mid_y_next = prev_mid_y_reg;
        if (accept) begin
            if (s_data.last_in_scan) begin
                have_prev_next  = 1'b0;
                prev_mid_x_next = '0;
                prev_mid_y_next = '0;
            end else if (kept) begin
                have_prev_next  = 1'b1;
                prev_mid_x_next = mid_x;
                prev_mid_y_next = mid_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg  <= 1'b0;
            prev_mid_x_reg <= '0;
            prev_mid_y_reg <= '0;
        end else begin
            have_prev_reg  <= have_prev_next;
            prev_mid_x_reg <= prev_mid_x_next;
            prev_mid_y_reg <= prev_mid_y_next;
        end
    end

endmodule

### design/spd_back.sv
// Back part: squares the length and gap components, checks the windows and
// drives the result register. Depends on spd_pkg.
module spd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  spd_pkg::spd_cfg_t   cfg,
    input  logic                q_empty,
    output logic                q_pop,
    input  spd_pkg::spd_entry_t q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output spd_pkg::spd_out_t   m_data
);
    import spd_pkg::*;

    function automatic logic [SQ_BITS-1:0] square(input logic signed [DIFF_BITS-1:0] d);
        logic signed [2*DIFF_BITS-1:0] p;
        p = (2*DIFF_BITS)'(d) * (2*DIFF_BITS)'(d);
        return p[SQ_BITS-1:0];
    endfunction

    function automatic logic [BOUND_SQ_BITS-1:0] hi_sq(input logic [LEN_BITS-1:0] n,
                                                       input logic [LEN_BITS-1:0] t);
        logic [BOUND_BITS-1:0] hi;
        hi = BOUND_BITS'(n) + BOUND_BITS'(t);
        return BOUND_SQ_BITS'(hi) * BOUND_SQ_BITS'(hi);
    endfunction

    // valid only when n > t, which is when the lower bound takes part
    function automatic logic [BOUND_SQ_BITS-1:0] lo_sq(input logic [LEN_BITS-1:0] n,
                                                       input logic [LEN_BITS-1:0] t);
        logic [LEN_BITS-1:0] lo;
        lo = n - t;
        return BOUND_SQ_BITS'(lo) * BOUND_SQ_BITS'(lo);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] to_out(
        input logic signed [COORD_BITS-1:0] v);
        logic signed [COORD_BITS+OUT_BITS-1:0] ext;
        ext = (COORD_BITS+OUT_BITS)'(v);
        return ext[OUT_BITS-1:0];
    endfunction

    // squared bounds, refreshed every cycle from the registers
    logic [BOUND_SQ_BITS-1:0] side_hi_sq_reg, side_lo_sq_reg;
    logic [BOUND_SQ_BITS-1:0] gap_hi_sq_reg, gap_lo_sq_reg;
    logic                     side_lo_on_reg, gap_lo_on_reg;

    always_ff @(posedge aclk) begin
        side_hi_sq_reg <= hi_sq(cfg.side_length, cfg.side_tolerance);
        side_lo_sq_reg <= lo_sq(cfg.side_length, cfg.side_tolerance);
        side_lo_on_reg <= cfg.side_length > cfg.side_tolerance;
        gap_hi_sq_reg  <= hi_sq(cfg.gap_length, cfg.gap_tolerance);
        gap_lo_sq_reg  <= lo_sq(cfg.gap_length, cfg.gap_tolerance);
        gap_lo_on_reg  <= cfg.gap_length > cfg.gap_tolerance;
    end

    // square stage
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_has_prev_reg;
    logic [SQ_BITS-1:0]           seg_dx_sq_reg, seg_dy_sq_reg;
    logic [SQ_BITS-1:0]           gap_dx_sq_reg, gap_dy_sq_reg;
    logic signed [COORD_BITS-1:0] s1_prev_mid_x_reg, s1_prev_mid_y_reg;
    logic signed [COORD_BITS-1:0] s1_mid_x_reg, s1_mid_y_reg;

    logic              out_free;
    logic              s1_take;
    logic [CMP_BITS-1:0] seg_sum, gap_sum;
    logic              len_ok, gap_ok, match;
    logic              prev_len_ok_reg, prev_len_ok_next;
    logic              m_valid_reg, m_valid_next;
    spd_out_t          m_data_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_take  = s1_valid_reg && out_free;
    assign q_pop    = !q_empty && (!s1_valid_reg || out_free);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_has_prev_reg   <= q_data.has_prev;
            seg_dx_sq_reg     <= square(q_data.seg_dx);
            seg_dy_sq_reg     <= square(q_data.seg_dy);
            gap_dx_sq_reg     <= square(q_data.gap_dx);
            gap_dy_sq_reg     <= square(q_data.gap_dy);
            s1_prev_mid_x_reg <= q_data.prev_mid_x;
            s1_prev_mid_y_reg <= q_data.prev_mid_y;
            s1_mid_x_reg      <= q_data.mid_x;
            s1_mid_y_reg      <= q_data.mid_y;
        end
    end

    // window checks on squared values; a lower bound at or below zero passes
    assign seg_sum = CMP_BITS'(seg_dx_sq_reg) + CMP_BITS'(seg_dy_sq_reg);
    assign gap_sum = CMP_BITS'(gap_dx_sq_reg) + CMP_BITS'(gap_dy_sq_reg);
    assign len_ok  = (!side_lo_on_reg || (seg_sum > CMP_BITS'(side_lo_sq_reg)))
                     && (seg_sum < CMP_BITS'(side_hi_sq_reg));
    assign gap_ok  = (!gap_lo_on_reg || (gap_sum > CMP_BITS'(gap_lo_sq_reg)))
                     && (gap_sum < CMP_BITS'(gap_hi_sq_reg));
    assign match   = s1_has_prev_reg && prev_len_ok_reg && len_ok && gap_ok;

    // stage control and length flag of the previous kept segment
    always_comb begin
        s1_valid_next    = s1_valid_reg;
        prev_len_ok_next = prev_len_ok_reg;
        m_valid_next     = m_valid_reg;
        if (s1_take) begin
            s1_valid_next    = 1'b0;
            prev_len_ok_next = len_ok;
        end
        if (q_pop) begin
            s1_valid_next = 1'b1;
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s1_take && match) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            prev_len_ok_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            s1_valid_reg    <= s1_valid_next;
            prev_len_ok_reg <= prev_len_ok_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (s1_take && match) begin
            m_data_reg.first_mid_x  <= to_out(s1_prev_mid_x_reg);
            m_data_reg.first_mid_y  <= to_out(s1_prev_mid_y_reg);
            m_data_reg.second_mid_x <= to_out(s1_mid_x_reg);
            m_data_reg.second_mid_y <= to_out(s1_mid_y_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/segment_pair_detector.sv
// Segment pair detector top level: configuration registers, front, queue and back.
// Depends on spd_pkg, spd_front, spd_queue and spd_back.
//
// Takes one line segment per cycle and reports pairs of kept segments whose
// lengths and midpoint distance fall inside the configured windows. An input
// request is accepted in any cycle in which the front-to-back queue has room,
// so the sustained rate is one segment per clock while m_ready stays high.
// A match passes through the queue, the square stage and the result register
// before it shows on m_valid; the depth of the queue (QUEUE_DEPTH entries) sets
// how long the result side may stall before s_ready drops. Configuration registers
// are always ready and take effect for segments accepted after the write.
module segment_pair_detector #(
    parameter int QUEUE_DEPTH = spd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  spd_pkg::spd_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output spd_pkg::spd_out_t                    m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [spd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import spd_pkg::*;

    localparam int ENTRY_BITS = $bits(spd_entry_t);

    spd_cfg_t            cfg_reg, cfg_next;
    logic                q_push, q_pop, q_full, q_empty;
    spd_entry_t          q_in, q_out;
    logic [ENTRY_BITS-1:0] q_in_bits, q_out_bits;

    // configuration registers; unused indexes are ignored
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_RADIUS_LOW:     cfg_next.radius_low     = cfg_data[RADIUS_BITS-1:0];
                CFG_RADIUS_HIGH:    cfg_next.radius_high    = cfg_data[RADIUS_BITS-1:0];
                CFG_SIDE_LENGTH:    cfg_next.side_length    = cfg_data[LEN_BITS-1:0];
                CFG_SIDE_TOLERANCE: cfg_next.side_tolerance = cfg_data[LEN_BITS-1:0];
                CFG_GAP_LENGTH:     cfg_next.gap_length     = cfg_data[LEN_BITS-1:0];
                CFG_GAP_TOLERANCE:  cfg_next.gap_tolerance  = cfg_data[LEN_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.radius_low     <= RADIUS_LOW_RST;
            cfg_reg.radius_high    <= RADIUS_HIGH_RST;
            cfg_reg.side_length    <= SIDE_LENGTH_RST;
            cfg_reg.side_tolerance <= SIDE_TOLERANCE_RST;
            cfg_reg.gap_length     <= GAP_LENGTH_RST;
            cfg_reg.gap_tolerance  <= GAP_TOLERANCE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: window, midpoints, pairing
    spd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    assign q_in_bits = q_in;
    assign q_out     = q_out_bits;

    // decoupling queue
    spd_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in_bits),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out_bits)
    );

    // back: squared windows and result register
    spd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_out),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### design/spd_checker.sv
// Port-level checks for the segment pair detector, bound to the top level.
// Depends on spd_pkg and segment_pair_detector_defines.svh.
`include "segment_pair_detector_defines.svh"

module spd_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input spd_pkg::spd_out_t m_data
);
    import spd_pkg::*;

    logic m_stall;

    assign m_stall = m_valid && !m_ready;

    // a stalled result keeps its request and payload
    `SPD_ASSERT_NEXT(a_result_hold, m_stall, m_valid && $stable(m_data), "stalled result moved")

    // reset empties the queue and the result register
    `SPD_ASSERT_RESET(a_reset_empty, !aresetn, !m_valid && s_ready, "not empty after reset")

    // no result right after reset: a result needs an accepted segment to pass through first
    `SPD_ASSERT_RESET(a_reset_latency, $past(!aresetn), !m_valid, "result too early after reset")

endmodule

bind segment_pair_detector spd_checker u_spd_checker (.*);

### test/segment_pair_detector_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for segment_pair_detector: segment requests in, midpoint pairs out.
// Depends on spd_pkg and the segment_pair_detector RTL.
module segment_pair_detector_test;
    import spd_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 3'd7;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 9;
    localparam int QUOTA [PHASES] = '{200, 40, 200, 200, 60, 60, 200, 190, 190};

    // Tracks the pairing state and registers, predicts midpoint pairs
    class pair_predictor;
        spd_cfg_t regs;
        bit       held;
        longint   held_mid_x;
        longint   held_mid_y;
        bit       held_len_ok;
        spd_out_t pending_pairs [$];
        int       errors;

        function new();
            regs = '{RADIUS_LOW_RST, RADIUS_HIGH_RST, SIDE_LENGTH_RST,
                     SIDE_TOLERANCE_RST, GAP_LENGTH_RST, GAP_TOLERANCE_RST};
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            held        = 1'b0;
            held_mid_x  = 0;
            held_mid_y  = 0;
            held_len_ok = 1'b0;
        endfunction

        function int pending();
            return pending_pairs.size();
        endfunction

        function void note_config(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_RADIUS_LOW:     regs.radius_low     = val;
                CFG_RADIUS_HIGH:    regs.radius_high    = val;
                CFG_SIDE_LENGTH:    regs.side_length    = val[LEN_BITS-1:0];
                CFG_SIDE_TOLERANCE: regs.side_tolerance = val[LEN_BITS-1:0];
                CFG_GAP_LENGTH:     regs.gap_length     = val[LEN_BITS-1:0];
                CFG_GAP_TOLERANCE:  regs.gap_tolerance  = val[LEN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // strict band on a squared length; a lower edge at or below zero always passes
        function bit in_band(longint sq, longint nominal, longint tol);
            longint lo;
            longint hi;
            lo = nominal - tol;
            hi = nominal + tol;
            if (lo > 0 && !(sq > lo * lo))
                return 1'b0;
            return sq < hi * hi;
        endfunction

        function longint dist_sq(longint ax, longint ay, longint bx, longint by);
            return (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
        endfunction

        function void note_segment(spd_in_t seg);
            longint   sx, sy, ex, ey, mx, my;
            bit       len_ok;
            spd_out_t pair;
            sx = $signed(seg.start_x);
            sy = $signed(seg.start_y);
            ex = $signed(seg.end_x);
            ey = $signed(seg.end_y);
            if (seg.radius > regs.radius_low && seg.radius < regs.radius_high) begin
                // arithmetic shift gives the floor of the half sum
                mx = (sx + ex) >>> 1;
                my = (sy + ey) >>> 1;
                len_ok = in_band(dist_sq(sx, sy, ex, ey), regs.side_length, regs.side_tolerance);
                if (held && held_len_ok && len_ok &&
                        in_band(dist_sq(held_mid_x, held_mid_y, mx, my),
                                regs.gap_length, regs.gap_tolerance)) begin
                    pair.first_mid_x  = held_mid_x[OUT_BITS-1:0];
                    pair.first_mid_y  = held_mid_y[OUT_BITS-1:0];
                    pair.second_mid_x = mx[OUT_BITS-1:0];
                    pair.second_mid_y = my[OUT_BITS-1:0];
                    pending_pairs = {pending_pairs, pair};
                end
                held        = 1'b1;
                held_mid_x  = mx;
                held_mid_y  = my;
                held_len_ok = len_ok;
            end
            if (seg.last_in_scan)
                clear_scan();
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        task compare_field(string name, logic [OUT_BITS-1:0] got, logic [OUT_BITS-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d expected %0d", name,
                                          $signed(got), $signed(want)));
        endtask

        task check_pair(spd_out_t got);
            spd_out_t want;
            if (pending_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair %p", got));
                return;
            end
            want = pending_pairs.pop_front();
            compare_field("first_mid_x", got.first_mid_x, want.first_mid_x);
            compare_field("first_mid_y", got.first_mid_y, want.first_mid_y);
            compare_field("second_mid_x", got.second_mid_x, want.second_mid_x);
            compare_field("second_mid_y", got.second_mid_y, want.second_mid_y);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    spd_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    spd_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_RADIUS_LOW;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    pair_predictor predictor = new();
    bit calm = 1'b0;
    int stall_left = 0;
    int cycles = 0;

    segment_pair_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("segment_pair_detector verification failed");
            $finish;
        end
    end

    // Result side: check accepted pairs, stall in short random bursts
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            predictor.check_pair(m_data);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 2) begin
            stall_left = $urandom_range(1, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic spd_in_t seg_of(int sx, int sy, int ex, int ey, int r, bit last);
        spd_in_t seg;
        seg.start_x      = sx[COORD_BITS-1:0];
        seg.start_y      = sy[COORD_BITS-1:0];
        seg.end_x        = ex[COORD_BITS-1:0];
        seg.end_y        = ey[COORD_BITS-1:0];
        seg.radius       = r[RADIUS_BITS-1:0];
        seg.last_in_scan = last;
        return seg;
    endfunction

    // One input request; valid stays high after acceptance unless an idle follows
    task automatic send_segment(spd_in_t seg);
        if (!calm && $urandom_range(0, 99) < 4) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= seg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predictor.note_segment(seg);
    endtask

    task automatic send_noise();
        spd_in_t seg;
        seg.start_x      = COORD_BITS'($urandom);
        seg.start_y      = COORD_BITS'($urandom);
        seg.end_x        = COORD_BITS'($urandom);
        seg.end_y        = COORD_BITS'($urandom);
        seg.radius       = RADIUS_BITS'($urandom);
        seg.last_in_scan = 1'($urandom_range(0, 1));
        send_segment(seg);
    endtask

    function automatic int aim(int nominal, int tol);
        int v;
        v = nominal + int'($urandom_range(0, 2 * tol + 4)) - tol - 2;
        if (v < 0) v = 0;
        if (v > 12000) v = 12000;
        return v;
    endfunction

    function automatic int kept_radius();
        int lo, hi;
        lo = predictor.regs.radius_low;
        hi = predictor.regs.radius_high;
        if (hi > lo + 1)
            return $urandom_range(lo + 1, hi - 1);
        return $urandom_range(0, 65535);
    endfunction

    // A scan of kept segments spaced so that neighbors tend to pair, with some noise mixed in
    task automatic send_scan(int count);
        int  mx, my, len, gap, dx, dy, sx, sy, r, i;
        real ang;
        mx = int'($urandom_range(0, 8000)) - 4000;
        my = int'($urandom_range(0, 8000)) - 4000;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 8)
                send_noise();
            len = aim(predictor.regs.side_length, predictor.regs.side_tolerance);
            ang = $urandom_range(0, 62831) / 10000.0;
            dx  = $rtoi(len * $cos(ang));
            dy  = $rtoi(len * $sin(ang));
            sx  = mx - dx / 2;
            sy  = my - dy / 2;
            r   = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 65535) : kept_radius();
            send_segment(seg_of(sx, sy, sx + dx, sy + dy, r, i == count - 1));
            gap = aim(predictor.regs.gap_length, predictor.regs.gap_tolerance);
            ang = $urandom_range(0, 62831) / 10000.0;
            mx += $rtoi(gap * $cos(ang));
            my += $rtoi(gap * $sin(ang));
            if (mx > 14000 || mx < -14000) mx = int'($urandom_range(0, 8000)) - 4000;
            if (my > 14000 || my < -14000) my = int'($urandom_range(0, 8000)) - 4000;
        end
    endtask

    // Lower valid, wait out every expected pair, then let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        predictor.note_config(idx, val);
    endtask

    // Upper bits of the 14-bit registers carry junk that must be dropped
    task automatic apply_settings(spd_cfg_t c, bit spare);
        write_reg(CFG_RADIUS_LOW, c.radius_low);
        write_reg(CFG_RADIUS_HIGH, c.radius_high);
        write_reg(CFG_SIDE_LENGTH, {2'($urandom_range(0, 3)), c.side_length});
        write_reg(CFG_SIDE_TOLERANCE, {2'($urandom_range(0, 3)), c.side_tolerance});
        write_reg(CFG_GAP_LENGTH, {2'($urandom_range(0, 3)), c.gap_length});
        write_reg(CFG_GAP_TOLERANCE, {2'($urandom_range(0, 3)), c.gap_tolerance});
        if (spare) begin
            write_reg(CFG_SPARE_A, 16'($urandom));
            write_reg(CFG_SPARE_B, 16'($urandom));
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        spd_cfg_t c;
        int p, sent, n;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under reset settings
        send_segment(seg_of(-65, 500, 65, 500, 1000, 0));      // radius on lower edge
        send_segment(seg_of(-65, 500, 65, 500, 3000, 0));      // radius on upper edge
        send_segment(seg_of(-65, 500, 65, 500, 1001, 0));
        send_segment(seg_of(635, 500, 765, 500, 2999, 0));     // nominal pair
        send_segment(seg_of(0, 0, 0, 0, 0, 0));                // rejected, state kept
        send_segment(seg_of(1335, 500, 1465, 500, 2000, 1));   // pair, then scan ends
        send_segment(seg_of(2035, 500, 2165, 500, 2000, 0));   // nothing held
        send_segment(seg_of(2750, 500, 2850, 500, 2000, 0));   // length on lower edge
        send_segment(seg_of(3435, 500, 3565, 500, 2000, 0));   // earlier length bad
        send_segment(seg_of(4635, 500, 4765, 500, 2000, 0));   // gap on upper edge
        send_segment(seg_of(5834, 500, 5964, 500, 2000, 0));   // gap just inside
        send_segment(seg_of(6034, 500, 6164, 500, 2000, 0));   // gap on lower edge
        send_segment(seg_of(0, 0, 0, 0, 65535, 1));            // rejected end of scan clears
        send_segment(seg_of(-3, -5, 0, 0, 1500, 0));           // negative half sums
        send_segment(seg_of(-72, -5, 58, -5, 1500, 0));
        send_segment(seg_of(-32768, -32768, 32767, 32767, 65535, 0));
        send_segment(seg_of(-32768, -32768, -32768, -32768, 1500, 0));
        send_segment(seg_of(32767, 32767, 32767, 32767, 1500, 1));
        send_segment(seg_of(32767, -32768, -32768, 32767, 2500, 0));
        send_segment(seg_of(-32768, 32767, 32767, -32768, 2500, 1));

        // Random phases, each under its own register settings
        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: c = '{RADIUS_LOW_RST, RADIUS_HIGH_RST, SIDE_LENGTH_RST,
                         SIDE_TOLERANCE_RST, GAP_LENGTH_RST, GAP_TOLERANCE_RST};
                1: c = '{16'd0, 16'd0, 14'd0, 14'd0, 14'd0, 14'd0};
                2: c = '{16'd0, 16'd65535, 14'd16383, 14'd16383, 14'd16383, 14'd16383};
                3: c = '{16'd0, 16'd65535, 14'd100, 14'd400, 14'd300, 14'd900};
                4: c = '{16'd500, 16'd40000, 14'd200, 14'd0, 14'd600, 14'd0};
                5: c = '{16'd65533, 16'd65535, 14'd50, 14'd60, 14'd16383, 14'd16383};
                default: begin
                    c.radius_low     = RADIUS_BITS'($urandom_range(0, 2000));
                    c.radius_high    = RADIUS_BITS'($urandom_range(3000, 65535));
                    c.side_length    = LEN_BITS'($urandom_range(20, 2000));
                    c.side_tolerance = LEN_BITS'($urandom_range(0, c.side_length));
                    c.gap_length     = LEN_BITS'($urandom_range(100, 8000));
                    c.gap_tolerance  = LEN_BITS'($urandom_range(1, c.gap_length));
                end
            endcase
            apply_settings(c, p == 0);
            calm = (p == 2);
            sent = 0;
            while (sent < QUOTA[p]) begin
                if ($urandom_range(0, 99) < 75) begin
                    n = $urandom_range(2, 8);
                    send_scan(n);
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_noise();
                end
                sent += n;
            end
            calm = 1'b0;
        end

        wait_idle();
        if (predictor.errors == 0 && predictor.pending() == 0)
            $display("segment_pair_detector verification clean");
        else
            $display("segment_pair_detector verification failed");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/spd_pkg.sv
design/spd_queue.sv
design/spd_front.sv
design/spd_back.sv
design/segment_pair_detector.sv
design/spd_checker.sv
test/segment_pair_detector_test.sv
